@@ hw/rtl/cptpl_pkg.sv @@
// package for the cp tensor prediction / loss block
// holds sizes, field widths, config and mode codes, the sequencer state type and a saturation helper
// no dependencies
package cptpl_pkg;

    localparam int MAX_WAYS_DEF = 4;
    localparam int MAX_RANK_DEF = 32;
    localparam int MAX_ROWS_DEF = 1024;

    localparam int VAL_W   = 32;
    localparam int IDX_W   = 10;
    localparam int TOT_W   = 63;
    localparam int CNT_W   = 32;
    localparam int NWAY_W  = 3;
    localparam int RANK_W  = 6;
    localparam int WSEL_W  = 2;
    localparam int RCOL_W  = 5;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_NUM_WAYS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_RANK     = 1'b1;

    localparam logic MODE_LOAD = 1'b0;
    localparam logic MODE_EVAL = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_READ,
        ST_MUL,
        ST_FOLD,
        ST_ERR,
        ST_ACC,
        ST_SQ,
        ST_TOT,
        ST_OUT
    } state_t;

    // saturate a signed 64-bit value to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh0000_0000_7FFF_FFFF)
            r = 32'sh7FFF_FFFF;
        else if (v < -64'sh0000_0000_8000_0000)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

@@ hw/rtl/cp_tensor_predict_loss.sv @@
// top level of the cp tensor prediction / loss block
// uses cptpl_pkg and cptpl_ram (one ram holds all factor matrices)
//
//  channel | dir | tdata (low bit first)                        | tuser / tlast
//  s_      | in  | value[31:0], index0..index3 (10 each)         | mode,way_sel,rank_col / last
//  m_      | out | predicted, error, sq_loss_total, abs_loss_tot, item_count | - / last_out
//  cfg_    | in  | cfg_index (0 num_ways, 1 rank), cfg_data      | -
//
// a load is taken in idle; loads can follow back to back. an evaluate does read,
// multiply and fold per way through one ram port and one 32x32 multiplier (way 0
// has no fold) for each rank column, then steps through prediction, error, square,
// totals and output; no new request is taken until the sequencer is back in idle.
// a stalled result holds the sequencer in its output state.
// reset (aresetn low, synchronous) clears control and totals; the store is
// undefined until loaded.
module cp_tensor_predict_loss
    import cptpl_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // value[31:0], index0[41:32], index1[51:42], index2[61:52], index3[71:62]
    input  logic [71:0]  s_tdata,
    // mode[0], way_sel[2:1], rank_col[7:3]
    input  logic [7:0]   s_tuser,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // predicted[31:0], error[63:32], sq_loss_total[126:64],
    // abs_loss_total[189:127], item_count[221:190]
    output logic [223:0] m_tdata,
    output logic         m_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [7:0]   cfg_data
);
    localparam int MAX_WAYS = MAX_WAYS_DEF;
    localparam int MAX_RANK = MAX_RANK_DEF;
    localparam int MAX_ROWS = MAX_ROWS_DEF;
    localparam int WAY_AW = $clog2(MAX_WAYS);
    localparam int ROW_AW = $clog2(MAX_ROWS);
    localparam int COL_AW = (MAX_RANK > 1) ? $clog2(MAX_RANK) : 1;
    localparam int DEPTH  = MAX_WAYS * MAX_ROWS * (1 << COL_AW);
    localparam int AW     = $clog2(DEPTH);
    localparam logic [63:0] TOT_MAX = 64'h7FFF_FFFF_FFFF_FFFF;

    state_t state_reg, state_next;

    logic [NWAY_W-1:0] num_ways_reg;
    logic [RANK_W-1:0] rank_reg;
    logic [NWAY_W-1:0] ways_eff;
    logic [RANK_W:0]   rank_eff;

    logic signed [31:0]     obs_reg;
    logic [IDX_W-1:0]       idx_reg [4];
    logic                   last_reg;
    logic [RANK_W:0]        f_reg;
    logic [NWAY_W-1:0]      w_reg;
    logic signed [31:0]     p_reg;
    logic signed [63:0]     prod_reg;
    logic signed [RANK_W+32:0] sum_reg;
    logic signed [31:0]     pred_reg, err_reg;
    logic [31:0]            mag_reg;
    logic [63:0]            sqr_reg;
    logic [63:0]            sq_reg, abs_reg;
    logic [CNT_W-1:0]       cnt_reg;

    logic        out_valid_reg;
    logic [223:0] out_data_reg;
    logic        out_last_reg;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr, ram_raddr;
    logic [31:0]       ram_rdata;

    logic        s_mode;
    logic [WSEL_W-1:0] s_wsel;
    logic [RCOL_W-1:0] s_rcol;
    logic        s_fire, out_free;
    logic signed [63:0] prod_sh;
    logic [IDX_W-1:0] cur_idx;
    logic signed [31:0] err_c;

    assign s_mode = s_tuser[0];
    assign s_wsel = s_tuser[2:1];
    assign s_rcol = s_tuser[7:3];

    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign s_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    always_comb begin
        ways_eff = num_ways_reg;
        if (ways_eff < NWAY_W'(2)) ways_eff = NWAY_W'(2);
        if (32'(ways_eff) > MAX_WAYS) ways_eff = NWAY_W'(MAX_WAYS);
        if (ways_eff > NWAY_W'(4)) ways_eff = NWAY_W'(4);
        rank_eff = {1'b0, rank_reg};
        if (32'(rank_eff) > MAX_RANK) rank_eff = (RANK_W+1)'(MAX_RANK);
    end

    // store write: loads in range only
    always_comb begin
        ram_we = s_fire && (s_mode == MODE_LOAD)
                 && (32'(s_wsel) < MAX_WAYS) && (32'(s_rcol) < MAX_RANK)
                 && (32'(s_tdata[41:32]) < MAX_ROWS);
        ram_waddr = AW'({s_wsel[WAY_AW-1:0], s_tdata[32 +: ROW_AW], s_rcol[COL_AW-1:0]});
    end

    assign cur_idx   = idx_reg[w_reg[1:0]];
    assign ram_raddr = AW'({w_reg[WAY_AW-1:0], cur_idx[ROW_AW-1:0], f_reg[COL_AW-1:0]});

    cptpl_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_store (
        .aclk(aclk), .we(ram_we), .waddr(ram_waddr), .wdata(s_tdata[31:0]),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    // floor shift then saturate
    assign prod_sh = prod_reg >>> 16;

    assign err_c = sat32(64'(obs_reg) - 64'(pred_reg));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: if (s_fire && s_mode == MODE_EVAL)
                state_next = (rank_eff == '0) ? ST_ERR : ST_READ;
            ST_READ: state_next = ST_MUL;
            // way 0 only seeds the running product
            ST_MUL: state_next = (w_reg == NWAY_W'(0)) ? ST_READ : ST_FOLD;
            ST_FOLD: begin
                if (w_reg + NWAY_W'(1) < ways_eff)
                    state_next = ST_READ;
                else if (f_reg + (RANK_W+1)'(1) < rank_eff)
                    state_next = ST_READ;
                else
                    state_next = ST_ERR;
            end
            ST_ERR: state_next = ST_ACC;
            ST_ACC: state_next = ST_SQ;
            ST_SQ:  state_next = ST_TOT;
            ST_TOT: state_next = ST_OUT;
            ST_OUT: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            num_ways_reg <= NWAY_W'(3);
            rank_reg     <= RANK_W'(16);
            sq_reg       <= '0;
            abs_reg      <= '0;
            cnt_reg      <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_NUM_WAYS: num_ways_reg <= cfg_data[NWAY_W-1:0];
                    CFG_RANK:     rank_reg     <= cfg_data[RANK_W-1:0];
                    default: ;
                endcase
            end
            if (state_reg == ST_TOT) begin
                sq_reg  <= (sq_reg > TOT_MAX - sqr_reg) ? TOT_MAX : sq_reg + sqr_reg;
                abs_reg <= (abs_reg > TOT_MAX - 64'(mag_reg)) ? TOT_MAX
                           : abs_reg + 64'(mag_reg);
                if (cnt_reg != '1) cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (state_reg == ST_OUT && out_free) begin
                out_valid_reg <= 1'b1;
                if (last_reg) begin
                    sq_reg  <= '0;
                    abs_reg <= '0;
                    cnt_reg <= '0;
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                obs_reg    <= s_tdata[31:0];
                idx_reg[0] <= s_tdata[41:32];
                idx_reg[1] <= s_tdata[51:42];
                idx_reg[2] <= s_tdata[61:52];
                idx_reg[3] <= s_tdata[71:62];
                last_reg   <= s_tlast;
                f_reg      <= '0;
                w_reg      <= '0;
                sum_reg    <= '0;
            end
            ST_MUL: begin
                if (w_reg == NWAY_W'(0)) begin
                    p_reg <= ram_rdata;
                    w_reg <= NWAY_W'(1);
                end else begin
                    prod_reg <= 64'(p_reg) * 64'(signed'(ram_rdata));
                end
            end
            ST_FOLD: begin
                if (w_reg + NWAY_W'(1) < ways_eff) begin
                    p_reg <= sat32(prod_sh);
                    w_reg <= w_reg + NWAY_W'(1);
                end else begin
                    sum_reg <= sum_reg + (RANK_W+33)'(sat32(prod_sh));
                    w_reg   <= '0;
                    f_reg   <= f_reg + (RANK_W+1)'(1);
                end
            end
            ST_ERR: pred_reg <= sat32(64'(sum_reg));
            ST_ACC: begin
                err_reg <= err_c;
                mag_reg <= err_c[31] ? 32'(-33'(err_c)) : 32'(err_c);
            end
            ST_SQ: sqr_reg <= 64'(mag_reg) * 64'(mag_reg);
            default: ;
        endcase
        if (state_reg == ST_OUT && out_free) begin
            out_data_reg <= {2'b0, cnt_reg, abs_reg[62:0], sq_reg[62:0],
                             err_reg, pred_reg};
            out_last_reg <= last_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    as_busy_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("request taken while busy");
    as_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && !out_free) |=> (state_reg == ST_OUT))
        else $error("result lost under stall");
    as_count_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && out_free && last_reg) |=> (cnt_reg == '0))
        else $error("totals not cleared after last");
endmodule

@@ hw/rtl/cptpl_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
// depends on nothing
module cptpl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end
endmodule
